// ----- src/shannon_entropy_of_counts_assert.svh -----
// assertion macros for the entropy block
`ifndef SHANNON_ENTROPY_OF_COUNTS_ASSERT_SVH
`define SHANNON_ENTROPY_OF_COUNTS_ASSERT_SVH

// implication checked on every clock edge outside reset
`define SEC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// implication with the consequent checked in the cycle after the antecedent
`define SEC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/sec_pkg.sv -----
// ----------------------------------------------------------------------------
// sec_pkg
// Types and constants shared by the entropy front end, queue and back end.
// ----------------------------------------------------------------------------
package sec_pkg;

    localparam int COUNT_BITS    = 20;
    localparam int FRACTION_BITS = 20;

    localparam int IN_BITS  = COUNT_BITS;
    localparam int OUT_BITS = FRACTION_BITS + 4;

    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    typedef struct packed {
        logic [IN_BITS-1:0] symbol_count;
        logic [IN_BITS-1:0] total_count;
        logic               last_symbol;
    } sec_in_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] entropy_nats;
        logic                bad_input;
    } sec_out_t;

    // classified item passed from front to back
    typedef struct packed {
        logic [IN_BITS-1:0] symbol_count;
        logic [IN_BITS-1:0] total_count;
        logic               use_term;
        logic               bad;
        logic               last;
    } sec_job_t;

endpackage

// ----- src/sec_front.sv -----
// ----------------------------------------------------------------------------
// sec_front
// Accepts input beats, flags bad totals and counts, and pushes jobs.
// ----------------------------------------------------------------------------
module sec_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sec_pkg::sec_in_t  s_data,
    output logic              job_valid,
    input  logic              job_ready,
    output sec_pkg::sec_job_t job_data
);
    import sec_pkg::*;

    logic     valid_reg;
    sec_job_t job_reg;
    logic     bad;

    assign s_ready   = !valid_reg || job_ready;
    assign job_valid = valid_reg;
    assign job_data  = job_reg;

    assign bad = (s_data.total_count == '0) || (s_data.symbol_count > s_data.total_count);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            job_reg.symbol_count <= s_data.symbol_count;
            job_reg.total_count  <= s_data.total_count;
            job_reg.bad          <= bad;
            job_reg.use_term     <= !bad && (s_data.symbol_count != '0);
            job_reg.last         <= s_data.last_symbol;
        end
    end
endmodule

// ----- src/sec_queue.sv -----
// ----------------------------------------------------------------------------
// sec_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module sec_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  sec_pkg::sec_job_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output sec_pkg::sec_job_t out_data
);
    import sec_pkg::*;

    sec_job_t   mem_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wr_reg <= !wr_reg;
            end
            if (pop) begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_data;
        end
    end
endmodule

// ----- src/sec_back.sv -----
// ----------------------------------------------------------------------------
// sec_back
// Computes -p*ln(p) per job with a shared squarer for the log, a restoring
// divider for p, and accumulates; emits the sum on the last job.
// ----------------------------------------------------------------------------
module sec_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_valid,
    output logic              job_ready,
    input  sec_pkg::sec_job_t job_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sec_pkg::sec_out_t m_data
);
    import sec_pkg::*;

    localparam int FB      = FRACTION_BITS;
    localparam int KB      = 5;
    localparam int LW      = KB + FB;
    localparam int SUM_W   = FB + 8;
    localparam int PW      = FB + 1;
    localparam int DIVW    = COUNT_BITS + FB;
    localparam int FCW     = $clog2(FB + 1);
    localparam int DCW     = $clog2(DIVW + 1);
    localparam int OUT_W   = FB + 4;
    localparam int EW      = LW + 30;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOGT  = 7'b0000010,
        ST_LOGC  = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_MULE  = 7'b0010000,
        ST_MULP  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [COUNT_BITS-1:0] c_reg, t_reg;
    logic                last_reg;
    logic [30:0]         m_reg;
    logic [FB-1:0]       frac_reg;
    logic [FCW-1:0]      fcnt_reg;
    logic [KB-1:0]       k_reg;
    logic [LW-1:0]       lt_reg;
    logic [LW-1:0]       d_reg;
    logic [DIVW-1:0]     quo_reg;
    logic [COUNT_BITS:0] rem_reg;
    logic [DCW-1:0]      dcnt_reg;
    logic [LW-1:0]       e_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic                err_reg;
    logic                out_valid_reg;
    sec_out_t            out_reg;

    logic [61:0]         sq;
    logic [31:0]         sq_sh;
    logic [KB-1:0]       top;
    logic [30:0]         norm;
    logic [COUNT_BITS-1:0] lg_src;
    logic [LW-1:0]       lg_val;
    logic [EW-1:0]       eprod;
    logic [LW+PW-1:0]    tprod;
    logic [SUM_W:0]      sum_add;
    logic [COUNT_BITS:0] rem_sh;
    logic [SUM_W-1:0]    sum_sat;
    logic                out_free;
    logic                emit;

    assign sq     = 62'(m_reg) * 62'(m_reg);
    assign sq_sh  = sq[61:30];
    assign lg_val = {k_reg, frac_reg};

    // leading one of the count being logged
    always_comb begin
        top = '0;
        for (int i = 0; i < COUNT_BITS; i++) begin
            if (lg_src[i]) begin
                top = KB'(i);
            end
        end
    end

    always_comb begin
        if (top > KB'(30)) begin
            norm = 31'(lg_src >> (top - KB'(30)));
        end else begin
            norm = 31'({{(31 + 32){1'b0}}, lg_src} << (KB'(30) - top));
        end
    end

    assign lg_src = (state_reg == ST_LOGT) ? c_reg : job_data.total_count[COUNT_BITS-1:0];

    assign rem_sh = {rem_reg[COUNT_BITS-1:0], quo_reg[DIVW-1]};
    assign eprod  = EW'(d_reg) * EW'(LN2_Q30) + (EW'(1) << 29);
    assign tprod  = (LW+PW)'(e_reg) * (LW+PW)'(quo_reg[PW-1:0]);
    assign sum_add = {1'b0, sum_reg} + (SUM_W+1)'(tprod[LW+PW-1:FB]);
    assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

    // a pending result only holds a last job at its output step
    assign out_free  = !out_valid_reg || m_ready;
    assign emit      = (state_reg == ST_OUT) && last_reg && out_free;
    assign job_ready = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (job_valid && job_ready) begin
                    state_next = job_data.use_term ? ST_LOGT : ST_OUT;
                end
            end
            ST_LOGT: if (fcnt_reg == FCW'(FB)) state_next = ST_LOGC;
            ST_LOGC: if (fcnt_reg == FCW'(FB)) state_next = ST_DIV;
            ST_DIV:  if (dcnt_reg == DCW'(DIVW)) state_next = ST_MULE;
            ST_MULE: state_next = ST_MULP;
            ST_MULP: state_next = ST_OUT;
            ST_OUT:  if (!last_reg || out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (job_valid && job_ready && job_data.bad) begin
                        err_reg <= 1'b1;
                    end
                end
                ST_MULP: sum_reg <= sum_sat;
                ST_OUT: begin
                    if (emit) begin
                        out_reg.entropy_nats <= OUT_BITS'((sum_reg > SUM_W'({OUT_W{1'b1}}))
                                                ? SUM_W'({OUT_W{1'b1}}) : sum_reg);
                        out_reg.bad_input    <= err_reg;
                        sum_reg              <= '0;
                        err_reg              <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                c_reg    <= job_data.symbol_count[COUNT_BITS-1:0];
                t_reg    <= job_data.total_count[COUNT_BITS-1:0];
                last_reg <= job_data.last;
                m_reg    <= norm;
                k_reg    <= top;
                frac_reg <= '0;
                fcnt_reg <= '0;
            end
            ST_LOGT, ST_LOGC: begin
                if (fcnt_reg == FCW'(FB)) begin
                    if (state_reg == ST_LOGT) begin
                        lt_reg   <= lg_val;
                        m_reg    <= norm;
                        k_reg    <= top;
                        frac_reg <= '0;
                        fcnt_reg <= '0;
                    end else begin
                        d_reg    <= (lt_reg > lg_val) ? lt_reg - lg_val : '0;
                        quo_reg  <= DIVW'(c_reg) << FB;
                        rem_reg  <= '0;
                        dcnt_reg <= '0;
                    end
                end else begin
                    fcnt_reg <= fcnt_reg + FCW'(1);
                    if (sq_sh[31]) begin
                        m_reg    <= sq_sh[31:1];
                        frac_reg <= {frac_reg[FB-2:0], 1'b1};
                    end else begin
                        m_reg    <= sq_sh[30:0];
                        frac_reg <= {frac_reg[FB-2:0], 1'b0};
                    end
                end
            end
            ST_DIV: begin
                if (dcnt_reg != DCW'(DIVW)) begin
                    dcnt_reg <= dcnt_reg + DCW'(1);
                    if (rem_sh >= {1'b0, t_reg}) begin
                        rem_reg <= rem_sh - {1'b0, t_reg};
                        quo_reg <= {quo_reg[DIVW-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[DIVW-2:0], 1'b0};
                    end
                end
            end
            ST_MULE: e_reg <= eprod[LW+29:30];
            default: ;
        endcase
    end
endmodule

// ----- src/shannon_entropy_of_counts.sv -----
// ----------------------------------------------------------------------------
// shannon_entropy_of_counts
// Shannon entropy in nats of a set of symbol counts, Q4.20 result per set.
// ----------------------------------------------------------------------------
// One count per input beat; a beat marked last returns the set's entropy and
// an error flag. The front end registers and classifies each beat and hands
// it through a two-entry queue to the back end, which computes each term with
// two log2 runs on a shared squarer, a restoring divider and two multiply
// steps for a nonzero valid count; a zero or bad count goes straight to the
// output step. The back end takes a new count only after finishing the last
// one, so its sequencer sets the rate; a result waiting at the output holds
// the back end only when it reaches the output step of the next last count.
module shannon_entropy_of_counts (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sec_pkg::sec_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sec_pkg::sec_out_t m_data
);
    import sec_pkg::*;
    `include "shannon_entropy_of_counts_assert.svh"

    logic     f_valid, f_ready, q_valid, q_ready;
    sec_job_t f_data, q_data;

    sec_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .job_valid(f_valid), .job_ready(f_ready), .job_data(f_data)
    );

    sec_queue u_queue (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
    );

    sec_back u_back (
        .aclk, .aresetn,
        .job_valid(q_valid), .job_ready(q_ready), .job_data(q_data),
        .m_valid, .m_ready, .m_data
    );

    `SEC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    `SEC_ASSERT_IMP(a_out_known, aclk, aresetn, m_valid, !$isunknown(m_data), "result has unknown bits")
endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for shannon_entropy_of_counts: drives sets of counts,
// predicts each set's entropy and error flag, checks every result beat.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sec_pkg::*;

    localparam int FRAC      = 20;
    localparam longint SUM_SAT = (64'd1 << (FRAC + 8)) - 1;
    localparam longint OUT_SAT = (64'd1 << (FRAC + 4)) - 1;
    localparam longint LIMIT   = 2000000;

    class entropy_scoreboard;
        longint unsigned acc_sum;
        bit              err_seen;
        sec_out_t        pending[$];
        int              errors;

        function new();
            acc_sum = 0;
            err_seen = 0;
            errors = 0;
        endfunction

        function longint unsigned log2_q(longint unsigned x);
            int k;
            longint unsigned m;
            longint unsigned frac;
            k = 0;
            frac = 0;
            for (int b = 0; b < 32; b++) if (x[b]) k = b;
            if (k > 30) m = x >> (k - 30);
            else m = x << (30 - k);
            for (int i = 0; i < FRAC; i++) begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd1 << 31)) begin
                    m = m >> 1;
                    frac = frac | 1;
                end
            end
            return (longint'(k) << FRAC) | frac;
        endfunction

        function void note_count(sec_in_t b);
            longint unsigned c, t, lt, lc, d, e, p;
            sec_out_t r;
            c = 64'(b.symbol_count);
            t = 64'(b.total_count);
            if (t == 0 || c > t) begin
                err_seen = 1;
            end else if (c != 0) begin
                lt = log2_q(t);
                lc = log2_q(c);
                d = (lt > lc) ? lt - lc : 0;
                e = (d * 64'd744261118 + (64'd1 << 29)) >> 30;
                p = (c << FRAC) / t;
                acc_sum += (e * p) >> FRAC;
                if (acc_sum > SUM_SAT) acc_sum = SUM_SAT;
            end
            if (b.last_symbol) begin
                r.entropy_nats = 24'((acc_sum > OUT_SAT) ? OUT_SAT : acc_sum);
                r.bad_input = err_seen;
                pending = {pending, r};
                acc_sum = 0;
                err_seen = 0;
            end
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(sec_out_t got);
            sec_out_t exp_r;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            exp_r = pending.pop_front();
            if (got.entropy_nats !== exp_r.entropy_nats)
                report($sformatf("entropy got %h want %h", got.entropy_nats,
                                 exp_r.entropy_nats));
            if (got.bad_input !== exp_r.bad_input)
                report($sformatf("bad_input got %b want %b", got.bad_input,
                                 exp_r.bad_input));
        endtask
    endclass

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    sec_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    sec_out_t m_data;

    entropy_scoreboard sb;
    longint cycles;
    bit     calm;       // no idling in the last part
    bit     hold_rx;    // long receiver hold-off

    shannon_entropy_of_counts u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stall bursts, checks every accepted beat
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_rx) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 11);
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
                if (m_valid && m_ready) sb.check_result(m_data);
            end
        end
    end

    task automatic send_count(input logic [19:0] c, input logic [19:0] t,
                              input logic last);
        sec_in_t b;
        b.symbol_count = c;
        b.total_count = t;
        b.last_symbol = last;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_count(b);
    endtask

    // well-formed set of n counts summing to t, with optional bad beats
    task automatic send_set(input int n, input logic [19:0] t, input bit noise);
        longint left;
        logic [19:0] c;
        left = t;
        for (int i = 0; i < n; i++) begin
            if (i == n - 1) c = 20'(left);
            else c = 20'($urandom_range(0, 32'(left)));
            left -= c;
            if (noise && $urandom_range(0, 5) == 0)
                c = (t == 20'hFFFFF) ? c : 20'(32'(t) + 32'd1 + $urandom_range(0, 3));
            send_count(c, t, i == n - 1);
        end
    endtask

    initial begin
        logic [19:0] t;
        int n;
        sb = new();
        cycles = 0;
        calm = 0;
        hold_rx = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners
        send_count(20'd0, 20'd0, 1'b1);               // zero total
        send_count(20'd5, 20'd4, 1'b1);               // count above total
        send_count(20'd0, 20'd10, 1'b1);              // zero count only
        send_count(20'hFFFFF, 20'hFFFFF, 1'b1);       // p = 1
        send_count(20'd1, 20'hFFFFF, 1'b0);
        send_count(20'hFFFFE, 20'hFFFFF, 1'b1);
        send_count(20'd1, 20'd2, 1'b0);
        send_count(20'd1, 20'd2, 1'b1);
        send_count(20'd3, 20'd7, 1'b0);
        send_count(20'd9, 20'd7, 1'b1);               // error on last beat
        for (int i = 0; i < 12; i++) send_count(20'd1, 20'hFFFFF, i == 11);
        for (int i = 0; i < 40; i++) send_count(20'd1, 20'd64, 1'b0);
        // large terms near 1/e nats each drive the result into saturation
        for (int i = 0; i < 60; i++) send_count(20'd385749, 20'hFFFFF, 1'b0);
        send_count(20'd1, 20'hFFFFF, 1'b1);

        // receiver holds off while the sender keeps offering beats
        fork
            begin
                hold_rx = 1;
                repeat (3000) @(posedge aclk);
                hold_rx = 0;
            end
            for (int i = 0; i < 10; i++)
                send_set(1, 20'($urandom_range(1, 20'hFFFFF)), 0);
        join

        for (int s = 0; s < 200; s++) begin
            if (s == 160) calm = 1;
            n = int'($urandom_range(1, 6));
            case ($urandom_range(0, 3))
                0: t = 20'($urandom_range(1, 255));
                1: t = 20'($urandom_range(1, 20'hFFFFF));
                2: t = 20'hFFFFF - 20'($urandom_range(0, 15));
                default: t = 20'($urandom_range(1, 16));
            endcase
            if ($urandom_range(0, 9) == 0)
                send_count(20'($urandom), 20'($urandom), 1'($urandom));
            else send_set(n, t, $urandom_range(0, 4) == 0);
        end
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+src
src/sec_pkg.sv
src/sec_front.sv
src/sec_queue.sv
src/sec_back.sv
src/shannon_entropy_of_counts.sv
tb/sv/testbench.sv
